[rtl/bdw_pkg.sv]
// Shared types and constants of the banked RAM-disk window.
`timescale 1ns / 1ps

package bdw_pkg;

    localparam int PAGE_ADDR_BITS = 16;

    localparam logic [7:0]  CTRL_PORT = 8'h10;
    localparam logic [15:0] WIN_LO    = 16'hA000;
    localparam logic [15:0] WIN_HI    = 16'hDFFF;
    localparam logic [1:0]  PAGE_TOP  = 2'd3;

    localparam int CW_SCREEN_SEL_LO = 0;
    localparam int CW_STACK_SEL_LO  = 2;
    localparam int CW_STACK_EN      = 4;
    localparam int CW_SCREEN_EN     = 5;

    typedef enum logic [2:0] {
        REQ_PORT_WR  = 3'd0,
        REQ_PORT_RD  = 3'd1,
        REQ_BYTE_RD  = 3'd2,
        REQ_BYTE_WR  = 3'd3,
        REQ_WORD_RD  = 3'd4,
        REQ_WORD_WR  = 3'd5,
        REQ_STACK_RD = 3'd6,
        REQ_STACK_WR = 3'd7
    } t_req_type;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_READ  = 3'b100
    } t_state;

endpackage

[rtl/bdw_if.sv]
// Request and response channel interfaces of the banked RAM-disk window.
`timescale 1ns / 1ps

interface bdw_req_if;
    import bdw_pkg::*;

    logic        valid;
    logic        ready;
    t_req_type   req_type;
    logic [7:0]  port_number;
    logic [15:0] address;
    logic [15:0] write_value;

    modport source (output valid, req_type, port_number, address, write_value, input ready);
    modport sink   (input valid, req_type, port_number, address, write_value, output ready);
endinterface

interface bdw_rsp_if;
    logic        valid;
    logic        ready;
    logic        claimed;
    logic [15:0] read_value;

    modport source (output valid, claimed, read_value, input ready);
    modport sink   (input valid, claimed, read_value, output ready);
endinterface

[rtl/bdw_bank.sv]
// One byte-wide RAM bank with a registered read port.
`timescale 1ns / 1ps

module bdw_bank #(
    parameter int ROWS = 131072
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [$clog2(ROWS)-1:0] i_row,
    input  logic [7:0]              i_wdata,
    output logic [7:0]              o_rdata
);

    logic [7:0] r_mem [ROWS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_row] <= i_wdata;
        end
        r_rdata <= r_mem[i_row];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/banked_ram_disk_window.sv]
// Top level of the banked RAM-disk window.
`timescale 1ns / 1ps

// Paged RAM disk of PAGE_COUNT pages of 64 KiB, held as two byte banks: even linear
// addresses in one, odd in the other, so a word at any address is one access. After
// reset the block clears the RAM and takes no request until that pass ends. A memory
// read goes through the registered read port of the banks and then the response
// register, and no request is taken in between; port requests, writes and misses
// load it directly. A request is taken while the previous result is handed over.
module banked_ram_disk_window #(
    parameter int PAGE_COUNT = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdw_req_if.sink   i_req,
    bdw_rsp_if.source o_rsp
);
    import bdw_pkg::*;

    localparam int RAM_SIZE = PAGE_COUNT * (2 ** PAGE_ADDR_BITS);
    localparam int ROWS     = RAM_SIZE / 2;
    localparam int LIN_W    = $clog2(RAM_SIZE);
    localparam int ROW_W    = LIN_W - 1;

    t_state             r_state, n_state;
    logic [15:0]        r_cw, n_cw;
    logic [ROW_W-1:0]   r_clr, n_clr;
    logic               r_out_valid, n_out_valid;
    logic               r_claimed, n_claimed;
    logic [15:0]        r_rdata, n_rdata;
    logic               r_swap, n_swap;
    logic               r_word, n_word;

    logic               w_ready, w_accept;
    logic               w_port_wr, w_port_rd, w_rd, w_wr, w_word, w_stack;
    logic               w_stack_hit, w_win_hit, w_hit;
    logic [1:0]         w_sel, w_pg_raw, w_page;
    logic [2:0]         w_pg_sub;
    logic [17:0]        w_lin_full;
    logic [LIN_W-1:0]   w_lin0, w_lin1;
    logic               w_even_we, w_odd_we;
    logic [ROW_W-1:0]   w_even_row, w_odd_row;
    logic [7:0]         w_even_wd, w_odd_wd, w_even_rd, w_odd_rd;
    logic [7:0]         w_lo, w_hi;

    always_comb begin
        w_port_wr = 1'b0;
        w_port_rd = 1'b0;
        w_rd      = 1'b0;
        w_wr      = 1'b0;
        w_word    = 1'b0;
        w_stack   = 1'b0;
        unique case (i_req.req_type)
            REQ_PORT_WR:  w_port_wr = 1'b1;
            REQ_PORT_RD:  w_port_rd = 1'b1;
            REQ_BYTE_RD:  w_rd = 1'b1;
            REQ_BYTE_WR:  w_wr = 1'b1;
            REQ_WORD_RD: begin
                w_rd   = 1'b1;
                w_word = 1'b1;
            end
            REQ_WORD_WR: begin
                w_wr   = 1'b1;
                w_word = 1'b1;
            end
            REQ_STACK_RD: begin
                w_rd    = 1'b1;
                w_word  = 1'b1;
                w_stack = 1'b1;
            end
            REQ_STACK_WR: begin
                w_wr    = 1'b1;
                w_word  = 1'b1;
                w_stack = 1'b1;
            end
            default: ;
        endcase
    end

    assign w_stack_hit = w_stack && r_cw[CW_STACK_EN];
    assign w_win_hit   = r_cw[CW_SCREEN_EN] && (i_req.address >= WIN_LO)
                         && (i_req.address <= WIN_HI);
    assign w_hit       = (w_rd || w_wr) && (w_stack_hit || w_win_hit);

    assign w_sel    = w_stack_hit ? r_cw[CW_STACK_SEL_LO +: 2] : r_cw[CW_SCREEN_SEL_LO +: 2];
    assign w_pg_raw = PAGE_TOP - w_sel;
    assign w_pg_sub = {1'b0, w_pg_raw} - 3'(PAGE_COUNT);
    assign w_page   = ({1'b0, w_pg_raw} >= 3'(PAGE_COUNT)) ? w_pg_sub[1:0] : w_pg_raw;

    assign w_lin_full = {w_page, i_req.address};
    assign w_lin0     = w_lin_full[LIN_W-1:0];
    assign w_lin1     = (w_lin0 == LIN_W'(RAM_SIZE - 1)) ? '0 : w_lin0 + 1'b1;

    assign w_ready  = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept = i_req.valid && w_ready;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_even_we  = 1'b1;
            w_odd_we   = 1'b1;
            w_even_row = r_clr;
            w_odd_row  = r_clr;
            w_even_wd  = '0;
            w_odd_wd   = '0;
        end else begin
            w_even_we  = w_accept && w_wr && w_hit && (w_word || !w_lin0[0]);
            w_odd_we   = w_accept && w_wr && w_hit && (w_word || w_lin0[0]);
            w_even_row = w_lin0[0] ? w_lin1[LIN_W-1:1] : w_lin0[LIN_W-1:1];
            w_odd_row  = w_lin0[LIN_W-1:1];
            w_even_wd  = w_lin0[0] ? i_req.write_value[15:8] : i_req.write_value[7:0];
            w_odd_wd   = w_lin0[0] ? i_req.write_value[7:0] : i_req.write_value[15:8];
        end
    end

    bdw_bank #(.ROWS(ROWS)) u_even (
        .i_clk   (i_clk),
        .i_we    (w_even_we),
        .i_row   (w_even_row),
        .i_wdata (w_even_wd),
        .o_rdata (w_even_rd)
    );

    bdw_bank #(.ROWS(ROWS)) u_odd (
        .i_clk   (i_clk),
        .i_we    (w_odd_we),
        .i_row   (w_odd_row),
        .i_wdata (w_odd_wd),
        .o_rdata (w_odd_rd)
    );

    assign w_lo = r_swap ? w_odd_rd : w_even_rd;
    assign w_hi = r_swap ? w_even_rd : w_odd_rd;

    always_comb begin
        n_state     = r_state;
        n_cw        = r_cw;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_claimed   = r_claimed;
        n_rdata     = r_rdata;
        n_swap      = r_swap;
        n_word      = r_word;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_swap = w_lin0[0];
                    n_word = w_word;
                    if (w_rd && w_hit) begin
                        n_state = ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_claimed   = w_port_wr || w_port_rd || w_hit;
                        n_rdata     = w_port_rd ? r_cw : '0;
                        if (w_port_wr && (i_req.port_number == CTRL_PORT)) begin
                            n_cw = i_req.write_value;
                        end
                    end
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_claimed   = 1'b1;
                n_rdata     = r_word ? {w_hi, w_lo} : {8'h00, w_lo};
                n_state     = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cw        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cw        <= n_cw;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_claimed <= n_claimed;
        r_rdata   <= n_rdata;
        r_swap    <= n_swap;
        r_word    <= n_word;
    end

    assign i_req.ready      = w_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.claimed    = r_claimed;
    assign o_rsp.read_value = r_rdata;

endmodule

[rtl/bdw_checker.sv]
// Port-level assertions of the banked RAM-disk window and their binding.
`timescale 1ns / 1ps

module bdw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [2:0]  i_req_type,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_claimed,
    input logic [15:0] i_rsp_read_value
);
    import bdw_pkg::*;

    logic w_req_acc;
    assign w_req_acc = i_req_valid && i_req_ready;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_claimed) |-> (i_rsp_read_value == 16'h0000))
        else $error("A missed request returned nonzero data.");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
        (i_rsp_valid && $stable(i_rsp_claimed) && $stable(i_rsp_read_value)))
        else $error("A stalled response changed.");

    a_port_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_acc && ((i_req_type == REQ_PORT_WR) || (i_req_type == REQ_PORT_RD)))
        |=> (i_rsp_valid && i_rsp_claimed))
        else $error("A port request was not answered as claimed in the next cycle.");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_acc && ((i_req_type == REQ_BYTE_WR) || (i_req_type == REQ_WORD_WR)
        || (i_req_type == REQ_STACK_WR)))
        |=> (i_rsp_valid && (i_rsp_read_value == 16'h0000)))
        else $error("A memory write did not answer with zero data in the next cycle.");

endmodule

bind banked_ram_disk_window bdw_checker u_bdw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_type       (i_req.req_type),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_claimed    (o_rsp.claimed),
    .i_rsp_read_value (o_rsp.read_value)
);

[tb/tb_top.sv]
// Self-checking testbench for the banked RAM-disk window: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
    import bdw_pkg::*;

    localparam int PAGE_COUNT       = 4;
    localparam int RAM_BYTES        = PAGE_COUNT << PAGE_ADDR_BITS;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int WATCHDOG_LIMIT   = 400000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int REPORT_LIMIT     = 10;
    localparam int HOT_COUNT        = 16;

    typedef struct {
        t_req_type   kind;
        logic [7:0]  port;
        logic [15:0] addr;
        logic [15:0] data;
    } disk_request_t;

    typedef struct {
        logic        claimed;
        logic [15:0] value;
    } disk_response_t;

    class ram_disk_scoreboard;
        logic [15:0]    control_word;
        logic [7:0]     disk_bytes [RAM_BYTES];
        disk_response_t pending_responses [$];
        int             mismatches;
        int             hits;
        int             misses;
        int             port_ops;
        int             responses_checked;

        function new();
            control_word = '0;
            foreach (disk_bytes[i]) disk_bytes[i] = '0;
            mismatches = 0;
            hits = 0;
            misses = 0;
            port_ops = 0;
            responses_checked = 0;
        endfunction

        function int page_base(logic [1:0] sel);
            int page;
            page = (int'(PAGE_TOP) - int'(sel)) % PAGE_COUNT;
            return page << PAGE_ADDR_BITS;
        endfunction

        function void note_request(disk_request_t r);
            disk_response_t predicted;
            logic           hit;
            int             base;
            int             lo;
            int             hi;
            predicted.claimed = 1'b0;
            predicted.value = '0;
            hit = 1'b0;
            base = 0;
            case (r.kind)
                REQ_PORT_WR: begin
                    if (r.port == CTRL_PORT) control_word = r.data;
                    predicted.claimed = 1'b1;
                    port_ops++;
                end
                REQ_PORT_RD: begin
                    predicted.claimed = 1'b1;
                    predicted.value = control_word;
                    port_ops++;
                end
                default: begin
                    if ((r.kind == REQ_STACK_RD || r.kind == REQ_STACK_WR)
                            && control_word[CW_STACK_EN]) begin
                        hit = 1'b1;
                        base = page_base(control_word[CW_STACK_SEL_LO +: 2]);
                    end else if (control_word[CW_SCREEN_EN] && r.addr >= WIN_LO
                            && r.addr <= WIN_HI) begin
                        hit = 1'b1;
                        base = page_base(control_word[CW_SCREEN_SEL_LO +: 2]);
                    end
                    // The high byte of a word may cross into the next page and wraps at the top.
                    lo = (base + int'(r.addr)) % RAM_BYTES;
                    hi = (lo + 1) % RAM_BYTES;
                    if (hit) begin
                        predicted.claimed = 1'b1;
                        hits++;
                        case (r.kind)
                            REQ_BYTE_RD: predicted.value = {8'h00, disk_bytes[lo]};
                            REQ_BYTE_WR: disk_bytes[lo] = r.data[7:0];
                            REQ_WORD_RD, REQ_STACK_RD: begin
                                predicted.value = {disk_bytes[hi], disk_bytes[lo]};
                            end
                            default: begin
                                disk_bytes[lo] = r.data[7:0];
                                disk_bytes[hi] = r.data[15:8];
                            end
                        endcase
                    end else begin
                        misses++;
                    end
                end
            endcase
            pending_responses.push_back(predicted);
        endfunction

        function void check_response(logic claimed, logic [15:0] value);
            disk_response_t predicted;
            if (pending_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: response with none pending: claimed=%0b read_value=%h",
                             $realtime, claimed, value);
                end
            end else begin
                predicted = pending_responses.pop_front();
                responses_checked++;
                if (claimed !== predicted.claimed || value !== predicted.value) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: mismatch: claimed exp %0b got %0b, read_value exp %h got %h",
                                 $realtime, predicted.claimed, claimed, predicted.value, value);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   idle_cycles = 0;
    logic [15:0] hot_addresses [HOT_COUNT];

    ram_disk_scoreboard sb = new();

    bdw_req_if req_bus ();
    bdw_rsp_if rsp_bus ();

    banked_ram_disk_window #(
        .PAGE_COUNT(PAGE_COUNT)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        disk_request_t accepted;
        logic          progress;
        progress = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                sb.check_response(rsp_bus.claimed, rsp_bus.read_value);
                progress = 1'b1;
            end
            if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
                accepted.kind = req_bus.req_type;
                accepted.port = req_bus.port_number;
                accepted.addr = req_bus.address;
                accepted.data = req_bus.write_value;
                sb.note_request(accepted);
                progress = 1'b1;
            end
        end
        if (progress) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a handshake.", idle_cycles);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drive_request(t_req_type kind, logic [7:0] port, logic [15:0] addr,
                                 logic [15:0] data);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= kind;
        req_bus.port_number <= port;
        req_bus.address     <= addr;
        req_bus.write_value <= data;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int          roll;
        t_req_type   kind;
        logic [7:0]  port;
        logic [15:0] addr;
        logic [15:0] data;
        roll = $urandom_range(0, 99);
        port = 8'($urandom_range(0, 255));
        addr = 16'($urandom_range(0, 65535));
        data = 16'($urandom_range(0, 65535));
        if (roll < 8) begin
            kind = REQ_PORT_WR;
            if ($urandom_range(0, 3) != 0) port = CTRL_PORT;
            data[CW_SCREEN_EN] = ($urandom_range(0, 3) != 0);
            data[CW_STACK_EN]  = ($urandom_range(0, 3) != 0);
        end else if (roll < 14) begin
            kind = REQ_PORT_RD;
        end else begin
            kind = t_req_type'($urandom_range(int'(REQ_BYTE_RD), int'(REQ_STACK_WR)));
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                addr = hot_addresses[$urandom_range(0, HOT_COUNT - 1)];
            end else if (roll < 80) begin
                addr = 16'($urandom_range(int'(WIN_LO), int'(WIN_HI)));
            end
        end
        drive_request(kind, port, addr, data);
    endtask

    task automatic run_directed();
        drive_request(REQ_PORT_RD,  8'h00,     16'h0000, 16'h0000);
        drive_request(REQ_BYTE_RD,  8'h00,     WIN_LO,   16'h0000);
        drive_request(REQ_STACK_RD, 8'h00,     16'h1234, 16'h0000);
        drive_request(REQ_PORT_WR,  8'h11,     16'h0000, 16'hFFFF);
        drive_request(REQ_PORT_RD,  8'hFF,     16'hFFFF, 16'hFFFF);
        // Screen window on page 3.
        drive_request(REQ_PORT_WR,  CTRL_PORT, 16'h0000, 16'h0020);
        drive_request(REQ_BYTE_WR,  8'h00,     WIN_LO,   16'hFF5A);
        drive_request(REQ_BYTE_RD,  8'h00,     WIN_LO,   16'h0000);
        drive_request(REQ_WORD_WR,  8'h00,     WIN_HI,   16'hBEEF);
        drive_request(REQ_WORD_RD,  8'h00,     WIN_HI,   16'h0000);
        drive_request(REQ_BYTE_RD,  8'h00,     16'h9FFF, 16'h0000);
        drive_request(REQ_BYTE_WR,  8'h00,     16'hE000, 16'h00AA);
        drive_request(REQ_STACK_RD, 8'h00,     16'hDFFE, 16'h0000);
        // Stack on page 3, screen on page 0; a word at the page end wraps to address zero.
        drive_request(REQ_PORT_WR,  CTRL_PORT, 16'h0000, 16'h0033);
        drive_request(REQ_STACK_WR, 8'h00,     16'hFFFF, 16'h1234);
        drive_request(REQ_STACK_RD, 8'h00,     16'hFFFF, 16'h0000);
        drive_request(REQ_PORT_WR,  CTRL_PORT, 16'h0000, 16'h003F);
        drive_request(REQ_STACK_RD, 8'h00,     16'h0000, 16'h0000);
        drive_request(REQ_STACK_WR, 8'h00,     16'hE000, 16'h5AA5);
        drive_request(REQ_PORT_WR,  CTRL_PORT, 16'hFFFF, 16'hFFC4);
        drive_request(REQ_WORD_RD,  8'h00,     WIN_LO,   16'h0000);
        drive_request(REQ_PORT_RD,  8'h10,     16'h0000, 16'h0000);
        drive_request(REQ_PORT_WR,  CTRL_PORT, 16'h0000, 16'h0035);
        drive_request(REQ_WORD_WR,  8'h00,     WIN_LO,   16'hCAFE);
        drive_request(REQ_STACK_RD, 8'h00,     WIN_LO,   16'h0000);
        drive_request(REQ_BYTE_WR,  8'h00,     16'hFFFF, 16'h0077);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_PORT_RD;
        req_bus.port_number = '0;
        req_bus.address     = '0;
        req_bus.write_value = '0;
        rsp_bus.ready       = 1'b0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        hot_addresses[0] = WIN_LO;
        hot_addresses[1] = WIN_HI;
        hot_addresses[2] = 16'hFFFF;
        hot_addresses[3] = 16'h0000;
        hot_addresses[4] = 16'h9FFF;
        hot_addresses[5] = 16'hE000;
        for (int i = 6; i < HOT_COUNT; i++) begin
            hot_addresses[i] = (i < 11) ? 16'($urandom_range(int'(WIN_LO), int'(WIN_HI)))
                                        : 16'($urandom_range(0, 65535));
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        send_idle_pct = 25;
        recv_idle_pct = 58;
        repeat (RANDOM_PER_PHASE) send_random_request();
        send_idle_pct = 58;
        recv_idle_pct = 25;
        repeat (RANDOM_PER_PHASE) send_random_request();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_request();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;

        while (sb.pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d responses: %0d port requests, %0d memory hits, %0d misses.",
                 sb.responses_checked, sb.port_ops, sb.hits, sb.misses);
        $display("Stall mixes: sender-heavy, receiver-heavy and none; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
